/* rtl/core/mld_pkg.sv */
package mld_pkg;

  localparam int MEAN_FRAC = 16;
  localparam int DLY_W     = 21;
  localparam int MEAN_W    = DLY_W + MEAN_FRAC;
  localparam int TOT_W     = 56;
  localparam int DVD_W     = 56;
  localparam int DVS_W     = 33;
  localparam int PROD_W    = 2 * MEAN_W;
  localparam int HALF_W    = (MEAN_W + 1) / 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_START_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROBE_FORMAT = 2'd1;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_EVENT = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam logic [7:0] ST_SPP   = 8'hF2;
  localparam logic [7:0] ST_SYSEX = 8'hF0;
  localparam logic [7:0] SYSEX_RT = 8'h7F;
  localparam logic [7:0] MTC_ID   = 8'h01;
  localparam logic [7:0] SYSEX_END = 8'hF7;

  typedef enum logic [1:0] {
    OP_PROBE3,
    OP_PROBE10,
    OP_MEASURE
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [31:0]      ctr;
    logic [DLY_W-1:0] dly;
  } cmd_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic              result_kind;
    logic [7:0]        probe_byte;
    logic              last;
    logic [DLY_W-1:0]  delay;
    logic [31:0]       sample_count;
    logic [DLY_W-1:0]  average_delay;
    logic [DLY_W-1:0]  min_delay;
    logic [DLY_W-1:0]  max_delay;
    logic [MEAN_W-1:0] running_mean;
    logic [63:0]       square_sum;
    logic [31:0]       last_signal_time;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_LOAD,
    S_WDIV,
    S_MUL,
    S_STAT,
    S_ADIV,
    S_OUT
  } bstate_t;

  function automatic logic [7:0] probe_at(input op_t op, input logic [3:0] k,
                                          input logic [31:0] c);
    logic [7:0] b;
    b = 8'h00;
    if (op == OP_PROBE3) begin
      unique case (k)
        4'd0: b = ST_SPP;
        4'd1: b = {1'b0, c[6:0]};
        4'd2: b = {1'b0, c[13:7]};
        default: b = 8'h00;
      endcase
    end else begin
      unique case (k)
        4'd0: b = ST_SYSEX;
        4'd1: b = SYSEX_RT;
        4'd2: b = SYSEX_RT;
        4'd3: b = MTC_ID;
        4'd4: b = MTC_ID;
        4'd5: b = {1'b0, c[6:0]};
        4'd6: b = {1'b0, c[13:7]};
        4'd7: b = {1'b0, c[20:14]};
        4'd8: b = {1'b0, c[27:21]};
        4'd9: b = SYSEX_END;
        default: b = 8'h00;
      endcase
    end
    return b;
  endfunction

endpackage

/* rtl/core/mld_if.sv */
interface mld_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [13:0] period_frames;
  logic [12:0] timestamp;
  logic [3:0] msg_length;
  logic [7:0] status_byte;
  logic [7:0] byte1;
  logic [7:0] byte2;
  logic [7:0] byte5;
  logic [7:0] byte6;
  logic [7:0] byte7;
  modport source(output valid, kind, period_frames, timestamp, msg_length, status_byte,
                 byte1, byte2, byte5, byte6, byte7, input ready);
  modport sink(input valid, kind, period_frames, timestamp, msg_length, status_byte,
               byte1, byte2, byte5, byte6, byte7, output ready);
endinterface

interface mld_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  probe_byte;
  logic        last;
  logic [20:0] delay;
  logic [31:0] sample_count;
  logic [20:0] average_delay;
  logic [20:0] min_delay;
  logic [20:0] max_delay;
  logic [36:0] running_mean;
  logic [63:0] square_sum;
  logic [31:0] last_signal_time;
  modport source(output valid, result_kind, probe_byte, last, delay, sample_count,
                 average_delay, min_delay, max_delay, running_mean, square_sum,
                 last_signal_time, input ready);
  modport sink(input valid, result_kind, probe_byte, last, delay, sample_count,
               average_delay, min_delay, max_delay, running_mean, square_sum,
               last_signal_time, output ready);
endinterface

/* rtl/core/mld_front.sv */
module mld_front #(
  parameter int COUNTER_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  mld_in_if.sink                          in_ch,
  input  logic                            cfg_we,
  input  logic [mld_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [mld_pkg::CFG_DAT_W-1:0]   cfg_data,
  input  logic                            q_full,
  output logic                            q_push,
  output mld_pkg::cmd_t                   q_cmd
);
  import mld_pkg::*;

  logic [COUNTER_BITS-1:0] cnt_r, cnt_nxt;
  logic                    fmt_r, fmt_nxt;
  logic                    acc;
  logic                    m3, m10;
  logic [DLY_W-1:0]        base, ti;

  assign in_ch.ready = !q_full;
  assign acc = in_ch.valid && in_ch.ready;

  always_comb begin
    m3   = (in_ch.msg_length == 4'd3) && (in_ch.status_byte == ST_SPP);
    m10  = (in_ch.msg_length == 4'd10) && (in_ch.status_byte == ST_SYSEX);
    base = DLY_W'(cnt_r) + DLY_W'(in_ch.timestamp);
    if (m3) begin
      ti = DLY_W'({in_ch.byte2[6:0], in_ch.byte1[6:0]});
    end else begin
      ti = {in_ch.byte7[6:0], in_ch.byte6[6:0], in_ch.byte5[6:0]};
    end
    q_cmd.ctr = 32'(cnt_r);
    q_cmd.dly = base - ti;
    if (m3) begin
      q_cmd.dly[DLY_W-1:14] = '0;
    end
    q_cmd.op = OP_MEASURE;
    q_push   = 1'b0;
    cnt_nxt  = cnt_r;
    fmt_nxt  = fmt_r;
    if (acc) begin
      unique case (in_ch.kind)
        KIND_START: begin
          q_cmd.op = fmt_r ? OP_PROBE10 : OP_PROBE3;
          q_push   = 1'b1;
        end
        KIND_EVENT: begin
          q_push = m3 || m10;
        end
        KIND_END: begin
          cnt_nxt = cnt_r + COUNTER_BITS'(in_ch.period_frames);
        end
        default: ;
      endcase
    end
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_START_COUNT:  cnt_nxt = COUNTER_BITS'(cfg_data);
        REG_PROBE_FORMAT: fmt_nxt = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= COUNTER_BITS'(48000);
      fmt_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      fmt_r <= fmt_nxt;
    end
  end

endmodule

/* rtl/core/mld_fifo.sv */
module mld_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mld_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output mld_pkg::cmd_t head
);
  import mld_pkg::*;

  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) empty |-> !pop)
    else $error("queue pop while empty");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count out of range");

endmodule

/* rtl/core/mld_div.sv */
module mld_div (
  input  logic              clk,
  input  logic              rst_n,
  input  mld_pkg::div_req_t req,
  output mld_pkg::div_rsp_t rsp
);
  import mld_pkg::*;

  localparam int CW = $clog2(DVD_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [DVS_W:0]   rem_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W:0]   rem_sh;
  logic             ge;

  always_comb begin
    rem_sh = {rem_r[DVS_W-1:0], quo_r[DVD_W-1]};
    ge     = rem_sh >= {1'b0, dvs_r};
  end

  assign rsp.quotient = quo_r;
  assign rsp.done     = done_r;

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? rem_sh - {1'b0, dvs_r} : rem_sh;
      quo_r <= {quo_r[DVD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DVD_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/core/mld_back.sv */
module mld_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  mld_pkg::cmd_t     q_head,
  output logic              q_pop,
  output mld_pkg::div_req_t dreq,
  input  mld_pkg::div_rsp_t drsp,
  mld_out_if.source         out_ch
);
  import mld_pkg::*;

  bstate_t           state_r, state_nxt;
  cmd_t              cmd_r;
  logic [3:0]        k_r, k_nxt;
  logic [1:0]        j_r, j_nxt;
  logic [31:0]       mcnt_r;
  logic [TOT_W-1:0]  tot_r;
  logic [DLY_W-1:0]  min_r, max_r, avg_r;
  logic [MEAN_W-1:0] mean_r, nw_r, da_r, db_r, x;
  logic [63:0]       sum_r;
  logic [31:0]       sig_r;
  logic [PROD_W-1:0] acc_r;
  logic              out_valid_r;
  res_t              out_r, res;
  logic              free, last_byte;
  logic [MEAN_W-1:0] q37, nw;
  logic [HALF_W-1:0] ap, bp;
  logic [2*HALF_W-1:0] pp;
  logic [PROD_W-1:0] pp_sh;
  logic [64:0]       sum_add;
  logic [TOT_W:0]    tot_add;
  logic [31:0]       mcnt_nxt;
  logic [TOT_W-1:0]  tot_nxt;

  assign free = !out_valid_r || out_ch.ready;
  assign x    = {cmd_r.dly, MEAN_FRAC'(0)};
  assign q37  = drsp.quotient[MEAN_W-1:0];
  assign last_byte = (cmd_r.op == OP_PROBE3) ? (k_r == 4'd2) : (k_r == 4'd9);

  always_comb begin
    nw    = (x >= mean_r) ? mean_r + q37 : mean_r - q37;
    ap    = j_r[0] ? HALF_W'(da_r[MEAN_W-1:HALF_W]) : da_r[HALF_W-1:0];
    bp    = j_r[1] ? HALF_W'(db_r[MEAN_W-1:HALF_W]) : db_r[HALF_W-1:0];
    pp    = ap * bp;
    pp_sh = PROD_W'(pp) << (HALF_W * (32'(j_r[0]) + 32'(j_r[1])));
    sum_add  = {1'b0, sum_r} + 65'(acc_r[PROD_W-1:MEAN_FRAC]);
    tot_add  = {1'b0, tot_r} + (TOT_W + 1)'(cmd_r.dly);
    tot_nxt  = tot_add[TOT_W] ? '1 : tot_add[TOT_W-1:0];
    mcnt_nxt = (mcnt_r == '1) ? mcnt_r : mcnt_r + 1'b1;
  end

  always_comb begin
    res = '0;
    if (state_r == S_PROBE) begin
      res.probe_byte = probe_at(cmd_r.op, k_r, cmd_r.ctr);
      res.last       = last_byte;
    end else begin
      res.result_kind      = 1'b1;
      res.last             = 1'b1;
      res.delay            = cmd_r.dly;
      res.sample_count     = mcnt_r;
      res.average_delay    = avg_r;
      res.min_delay        = min_r;
      res.max_delay        = max_r;
      res.running_mean     = mean_r;
      res.square_sum       = sum_r;
      res.last_signal_time = sig_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    q_pop         = 1'b0;
    dreq.start    = 1'b0;
    dreq.dividend = DVD_W'((x >= mean_r) ? x - mean_r : mean_r - x);
    dreq.divisor  = DVS_W'(mcnt_r) + 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          k_nxt     = '0;
          state_nxt = (q_head.op == OP_MEASURE) ? S_LOAD : S_PROBE;
        end
      end
      S_PROBE: begin
        if (free) begin
          k_nxt = k_r + 1'b1;
          if (last_byte) state_nxt = S_IDLE;
        end
      end
      S_LOAD: begin
        if (mcnt_r == '0) begin
          state_nxt = S_STAT;
        end else begin
          dreq.start = 1'b1;
          state_nxt  = S_WDIV;
        end
      end
      S_WDIV: begin
        j_nxt = '0;
        if (drsp.done) state_nxt = S_MUL;
      end
      S_MUL: begin
        j_nxt = j_r + 1'b1;
        if (j_r == 2'd3) state_nxt = S_STAT;
      end
      S_STAT: begin
        dreq.start    = 1'b1;
        dreq.dividend = DVD_W'(tot_nxt);
        dreq.divisor  = DVS_W'(mcnt_nxt);
        state_nxt     = S_ADIV;
      end
      S_ADIV: begin
        if (drsp.done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) cmd_r <= q_head;
    if (state_r == S_LOAD) begin
      nw_r  <= x;
      acc_r <= '0;
    end
    if (state_r == S_WDIV && drsp.done) begin
      nw_r  <= nw;
      da_r  <= (x >= nw) ? x - nw : nw - x;
      db_r  <= (x >= mean_r) ? x - mean_r : mean_r - x;
      acc_r <= '0;
    end
    if (state_r == S_MUL) acc_r <= acc_r + pp_sh;
    if (state_r == S_ADIV && drsp.done) begin
      avg_r <= (drsp.quotient > DVD_W'({DLY_W{1'b1}})) ? '1 : drsp.quotient[DLY_W-1:0];
    end
    if ((state_r == S_PROBE || state_r == S_OUT) && free) out_r <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
      mcnt_r      <= '0;
      tot_r       <= '0;
      min_r       <= '1;
      max_r       <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      j_r     <= j_nxt;
      if (free) out_valid_r <= (state_r == S_PROBE) || (state_r == S_OUT);
      if (state_r == S_STAT) begin
        mcnt_r <= mcnt_nxt;
        tot_r  <= tot_nxt;
        if (cmd_r.dly < min_r) min_r <= cmd_r.dly;
        if (cmd_r.dly > max_r) max_r <= cmd_r.dly;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r <= '0;
      sum_r  <= '0;
      sig_r  <= '0;
    end else if (state_r == S_STAT) begin
      mean_r <= nw_r;
      sum_r  <= sum_add[64] ? '1 : sum_add[63:0];
      sig_r  <= cmd_r.ctr;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.result_kind      = out_r.result_kind;
  assign out_ch.probe_byte       = out_r.probe_byte;
  assign out_ch.last             = out_r.last;
  assign out_ch.delay            = out_r.delay;
  assign out_ch.sample_count     = out_r.sample_count;
  assign out_ch.average_delay    = out_r.average_delay;
  assign out_ch.min_delay        = out_r.min_delay;
  assign out_ch.max_delay        = out_r.max_delay;
  assign out_ch.running_mean     = out_r.running_mean;
  assign out_ch.square_sum       = out_r.square_sum;
  assign out_ch.last_signal_time = out_r.last_signal_time;

  a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.done |-> (state_r == S_WDIV || state_r == S_ADIV))
    else $error("divider done outside a wait state");
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (mcnt_r != '0) |-> (min_r <= max_r))
    else $error("min above max");
  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (mcnt_r >= $past(mcnt_r)))
    else $error("measurement count went down");

endmodule

/* rtl/core/midi_loopback_delay_meter.sv */
// channel | dir | handshake     | payload
// in_ch   | in  | valid & ready | kind, period_frames, timestamp, msg, echo bytes
// out_ch  | out | valid & ready | probe byte or delay with statistics
// cfg     | in  | cfg_we        | cfg_idx, cfg_data (start_count, probe_format)
// A probe sends 3 or 10 bytes, one byte per cycle while out_ch is not stalled; a period end
// or a dropped event stays in the front end. A measurement uses two passes of the shared
// one-bit-per-cycle divider (Welford step, then average) and four partial products for
// the squared deviation; the first measurement makes only the average pass, with no products.
// Reset is synchronous; it clears the queue, the statistics and loads the counter.
// A two-entry queue lets the input side run ahead while the back end stalls.
module midi_loopback_delay_meter #(
  parameter int COUNTER_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  mld_in_if.sink                        in_ch,
  mld_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [mld_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [mld_pkg::CFG_DAT_W-1:0] cfg_data
);
  import mld_pkg::*;

  logic     q_full, q_empty, q_push, q_pop;
  cmd_t     q_cmd, q_head;
  div_req_t dreq;
  div_rsp_t drsp;

  mld_front #(.COUNTER_BITS(COUNTER_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .q_full(q_full), .q_push(q_push), .q_cmd(q_cmd)
  );

  mld_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_cmd(q_cmd),
    .pop(q_pop), .full(q_full), .empty(q_empty), .head(q_head)
  );

  mld_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  mld_back u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_head(q_head), .q_pop(q_pop),
    .dreq(dreq), .drsp(drsp), .out_ch(out_ch)
  );

endmodule

/* test/tb_midi_loopback_delay_meter.sv */
module tb_midi_loopback_delay_meter;
  timeunit 1ns;
  timeprecision 1ps;
  import mld_pkg::*;

  localparam logic [20:0] MASK21 = 21'h1FFFFF;
  localparam logic [55:0] MASK56 = {56{1'b1}};
  localparam int TIMEOUT_CYCLES = 900000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  mld_in_if in_ch();
  mld_out_if out_ch();

  midi_loopback_delay_meter u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  typedef struct {
    logic [1:0] kind;
    logic [13:0] period_frames;
    logic [12:0] timestamp;
    logic [3:0] msg_length;
    logic [7:0] status_byte;
    logic [7:0] byte1, byte2, byte5, byte6, byte7;
  } midi_txn_t;

  // meter state mirror
  logic [31:0] reg_start;
  logic        reg_format;
  logic [31:0] counter;
  logic [31:0] meas_count;
  logic [55:0] total;
  logic [20:0] min_d, max_d, avg_d;
  logic [63:0] w_mean;
  logic [63:0] w_sum;
  logic [31:0] sig_time;

  res_t expected_q[$];
  int   fail_count = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  longint cycle_count = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = '0;
    in_ch.period_frames = '0;
    in_ch.timestamp = '0;
    in_ch.msg_length = '0;
    in_ch.status_byte = '0;
    in_ch.byte1 = '0;
    in_ch.byte2 = '0;
    in_ch.byte5 = '0;
    in_ch.byte6 = '0;
    in_ch.byte7 = '0;
    out_ch.ready = 1'b0;
  end

  task automatic reset_mirror();
    reg_start = 32'd48000;
    reg_format = 1'b0;
    counter = reg_start;
    meas_count = '0;
    total = '0;
    min_d = MASK21;
    max_d = '0;
    avg_d = '0;
    w_mean = '0;
    w_sum = '0;
    sig_time = '0;
  endtask

  function automatic res_t probe_res(logic [7:0] b, logic lst);
    res_t r;
    r = '0;
    r.probe_byte = b;
    r.last = lst;
    return r;
  endfunction

  task automatic record_delay(logic [20:0] d);
    logic [63:0] x, nw, da, db, add;
    logic [127:0] prod;
    logic [63:0] n, avg;
    res_t r;
    x = 64'(d) << MEAN_FRAC;
    sig_time = counter;
    if (meas_count == 0) begin
      w_mean = x;
    end else begin
      n = 64'(meas_count) + 1;
      if (x >= w_mean) nw = w_mean + (x - w_mean) / n;
      else nw = w_mean - (w_mean - x) / n;
      da = (x >= nw) ? x - nw : nw - x;
      db = (x >= w_mean) ? x - w_mean : w_mean - x;
      prod = 128'(da) * 128'(db);
      if ((prod >> MEAN_FRAC) >> 64 != 0) add = '1;
      else add = 64'(prod >> MEAN_FRAC);
      w_sum = (w_sum > ~add) ? '1 : w_sum + add;
      w_mean = nw;
    end
    if (meas_count != '1) meas_count++;
    total = (57'(total) + 57'(d) > 57'(MASK56)) ? MASK56 : total + 56'(d);
    avg = 64'(total) / 64'(meas_count);
    avg_d = (avg > 64'(MASK21)) ? MASK21 : avg[20:0];
    if (d < min_d) min_d = d;
    if (d > max_d) max_d = d;
    r = '0;
    r.result_kind = 1'b1;
    r.last = 1'b1;
    r.delay = d;
    r.sample_count = meas_count;
    r.average_delay = avg_d;
    r.min_delay = min_d;
    r.max_delay = max_d;
    r.running_mean = w_mean[36:0];
    r.square_sum = w_sum;
    r.last_signal_time = sig_time;
    expected_q.push_back(r);
  endtask

  task automatic predict_meter(midi_txn_t t);
    logic [31:0] c;
    logic [20:0] ti;
    c = counter;
    if (t.kind == KIND_START) begin
      if (!reg_format) begin
        expected_q.push_back(probe_res(ST_SPP, 1'b0));
        expected_q.push_back(probe_res({1'b0, c[6:0]}, 1'b0));
        expected_q.push_back(probe_res({1'b0, c[13:7]}, 1'b1));
      end else begin
        expected_q.push_back(probe_res(ST_SYSEX, 1'b0));
        expected_q.push_back(probe_res(SYSEX_RT, 1'b0));
        expected_q.push_back(probe_res(SYSEX_RT, 1'b0));
        expected_q.push_back(probe_res(MTC_ID, 1'b0));
        expected_q.push_back(probe_res(MTC_ID, 1'b0));
        expected_q.push_back(probe_res({1'b0, c[6:0]}, 1'b0));
        expected_q.push_back(probe_res({1'b0, c[13:7]}, 1'b0));
        expected_q.push_back(probe_res({1'b0, c[20:14]}, 1'b0));
        expected_q.push_back(probe_res({1'b0, c[27:21]}, 1'b0));
        expected_q.push_back(probe_res(SYSEX_END, 1'b1));
      end
    end else if (t.kind == KIND_EVENT) begin
      if (t.msg_length == 4'd3 && t.status_byte == ST_SPP) begin
        ti = {7'd0, t.byte2[6:0], t.byte1[6:0]};
        record_delay({7'd0, 14'(c + 32'(t.timestamp) - 32'(ti))});
      end else if (t.msg_length == 4'd10 && t.status_byte == ST_SYSEX) begin
        ti = {t.byte7[6:0], t.byte6[6:0], t.byte5[6:0]};
        record_delay(21'(c + 32'(t.timestamp) - 32'(ti)));
      end
    end else if (t.kind == KIND_END) begin
      counter = c + 32'(t.period_frames);
    end
  endtask

  task automatic send_txn(midi_txn_t t);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= t.kind;
    in_ch.period_frames <= t.period_frames;
    in_ch.timestamp <= t.timestamp;
    in_ch.msg_length <= t.msg_length;
    in_ch.status_byte <= t.status_byte;
    in_ch.byte1 <= t.byte1;
    in_ch.byte2 <= t.byte2;
    in_ch.byte5 <= t.byte5;
    in_ch.byte6 <= t.byte6;
    in_ch.byte7 <= t.byte7;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_meter(t);
  endtask

  always @(posedge clk) begin
    res_t got, exp_r;
    if (rst_n) out_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.result_kind = out_ch.result_kind;
      got.probe_byte = out_ch.probe_byte;
      got.last = out_ch.last;
      got.delay = out_ch.delay;
      got.sample_count = out_ch.sample_count;
      got.average_delay = out_ch.average_delay;
      got.min_delay = out_ch.min_delay;
      got.max_delay = out_ch.max_delay;
      got.running_mean = out_ch.running_mean;
      got.square_sum = out_ch.square_sum;
      got.last_signal_time = out_ch.last_signal_time;
      if (expected_q.size() == 0) begin
        $error("unexpected transaction: kind %0d byte %h", got.result_kind, got.probe_byte);
        fail_count++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got.result_kind !== exp_r.result_kind) begin
          $error("result_kind exp %h got %h", exp_r.result_kind, got.result_kind); fail_count++;
        end
        if (got.probe_byte !== exp_r.probe_byte) begin
          $error("probe_byte exp %h got %h", exp_r.probe_byte, got.probe_byte); fail_count++;
        end
        if (got.last !== exp_r.last) begin
          $error("last exp %h got %h", exp_r.last, got.last); fail_count++;
        end
        if (got.delay !== exp_r.delay) begin
          $error("delay exp %0d got %0d", exp_r.delay, got.delay); fail_count++;
        end
        if (got.sample_count !== exp_r.sample_count) begin
          $error("sample_count exp %0d got %0d", exp_r.sample_count, got.sample_count);
          fail_count++;
        end
        if (got.average_delay !== exp_r.average_delay) begin
          $error("average_delay exp %0d got %0d", exp_r.average_delay, got.average_delay);
          fail_count++;
        end
        if (got.min_delay !== exp_r.min_delay) begin
          $error("min_delay exp %0d got %0d", exp_r.min_delay, got.min_delay); fail_count++;
        end
        if (got.max_delay !== exp_r.max_delay) begin
          $error("max_delay exp %0d got %0d", exp_r.max_delay, got.max_delay); fail_count++;
        end
        if (got.running_mean !== exp_r.running_mean) begin
          $error("running_mean exp %h got %h", exp_r.running_mean, got.running_mean);
          fail_count++;
        end
        if (got.square_sum !== exp_r.square_sum) begin
          $error("square_sum exp %h got %h", exp_r.square_sum, got.square_sum); fail_count++;
        end
        if (got.last_signal_time !== exp_r.last_signal_time) begin
          $error("last_signal_time exp %h got %h", exp_r.last_signal_time,
                 got.last_signal_time);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_START_COUNT) begin
      reg_start = val;
      counter = val;
    end else if (idx == REG_PROBE_FORMAT) begin
      reg_format = val[0];
    end
    @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic midi_txn_t noise_txn();
    midi_txn_t t;
    t.kind = 2'($urandom_range(3));
    t.period_frames = 14'($urandom);
    t.timestamp = 13'($urandom);
    t.msg_length = 4'($urandom);
    t.status_byte = 8'($urandom);
    t.byte1 = 8'($urandom);
    t.byte2 = 8'($urandom);
    t.byte5 = 8'($urandom);
    t.byte6 = 8'($urandom);
    t.byte7 = 8'($urandom);
    return t;
  endfunction

  function automatic midi_txn_t make_txn(logic [1:0] k, logic [13:0] pf, logic [12:0] ts,
                                         logic [3:0] len, logic [7:0] st, logic [7:0] b);
    midi_txn_t t;
    t.kind = k;
    t.period_frames = pf;
    t.timestamp = ts;
    t.msg_length = len;
    t.status_byte = st;
    t.byte1 = b;
    t.byte2 = b;
    t.byte5 = b;
    t.byte6 = b;
    t.byte7 = b;
    return t;
  endfunction

  task automatic test_directed();
    send_txn(make_txn(KIND_START, 0, 0, 0, 0, 0));
    send_txn(make_txn(KIND_EVENT, 0, 13'h1FFF, 4'd3, ST_SPP, 8'hFF));
    send_txn(make_txn(KIND_EVENT, 0, 0, 4'd3, ST_SPP, 8'h00));
    send_txn(make_txn(KIND_END, 14'd8192, 0, 0, 0, 0));
    send_txn(make_txn(KIND_END, 14'h3FFF, 0, 0, 0, 0));
    send_txn(make_txn(2'd3, 14'h3FFF, 13'h1FFF, 4'hF, 8'hFF, 8'hFF));
    send_txn(make_txn(KIND_EVENT, 0, 5, 4'd10, ST_SPP, 8'h12));
    send_txn(make_txn(KIND_EVENT, 0, 5, 4'd3, ST_SYSEX, 8'h12));
    send_txn(make_txn(KIND_EVENT, 0, 5, 4'hF, 8'hFF, 8'h12));
    drain();
    write_reg(REG_PROBE_FORMAT, 32'd1);
    write_reg(2'd3, 32'hFFFF_FFFF);
    write_reg(2'd2, 32'd0);
    send_txn(make_txn(KIND_START, 0, 0, 0, 0, 0));
    send_txn(make_txn(KIND_EVENT, 0, 13'h1FFF, 4'd10, ST_SYSEX, 8'hFF));
    send_txn(make_txn(KIND_EVENT, 0, 0, 4'd10, ST_SYSEX, 8'h80));
    send_txn(make_txn(KIND_EVENT, 0, 100, 4'd10, ST_SYSEX, 8'h00));
    drain();
    write_reg(REG_START_COUNT, 32'hFFFF_FFF0);
    send_txn(make_txn(KIND_START, 0, 0, 0, 0, 0));
    send_txn(make_txn(KIND_END, 14'd8192, 0, 0, 0, 0));
    send_txn(make_txn(KIND_START, 0, 0, 0, 0, 0));
    send_txn(make_txn(KIND_EVENT, 0, 7, 4'd3, ST_SPP, 8'h55));
    drain();
    write_reg(REG_START_COUNT, 32'd0);
    write_reg(REG_PROBE_FORMAT, 32'd0);
    send_txn(make_txn(KIND_START, 0, 0, 0, 0, 0));
    send_txn(make_txn(KIND_EVENT, 0, 0, 4'd3, ST_SPP, 8'h00));
    drain();
  endtask

  task automatic test_random_phase(int n, int idle_pct, int stall_pct);
    midi_txn_t t;
    logic [31:0] c;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      t = noise_txn();
      c = counter;
      case ($urandom_range(9))
        0, 1: t.kind = KIND_START;
        2, 3: begin
          t.kind = KIND_END;
          t.period_frames = ($urandom_range(9) == 0) ? 14'd8192 : 14'($urandom_range(1024));
        end
        4, 5, 6: begin
          t.kind = KIND_EVENT;
          t.msg_length = 4'd3;
          t.status_byte = ST_SPP;
          if ($urandom_range(1)) begin
            t.byte1 = {t.byte1[7], c[6:0]};
            t.byte2 = {t.byte2[7], c[13:7]};
            t.timestamp = 13'($urandom_range(2000));
          end
        end
        7, 8: begin
          t.kind = KIND_EVENT;
          t.msg_length = 4'd10;
          t.status_byte = ST_SYSEX;
          if ($urandom_range(1)) begin
            t.byte5 = {t.byte5[7], c[6:0]};
            t.byte6 = {t.byte6[7], c[13:7]};
            t.byte7 = {t.byte7[7], c[20:14]};
            t.timestamp = 13'($urandom_range(2000));
          end
        end
        default: ;
      endcase
      send_txn(t);
    end
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_random();
    test_random_phase(90, 0, 0);
    write_reg(REG_PROBE_FORMAT, 32'd1);
    write_reg(REG_START_COUNT, $urandom);
    test_random_phase(90, 52, 0);
    write_reg(REG_PROBE_FORMAT, 32'd0);
    test_random_phase(90, 0, 52);
    write_reg(REG_PROBE_FORMAT, 32'($urandom_range(1)));
    write_reg(REG_START_COUNT, 32'hFFFF_FFFF);
    test_random_phase(90, 29, 29);
  endtask

  initial begin
    reset_mirror();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
